>>> design/fixed_width_bit_packer_top_macros.svh
`ifndef FIXED_WIDTH_BIT_PACKER_TOP_MACROS_SVH
`define FIXED_WIDTH_BIT_PACKER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define FWBP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fwbp assertion failed");

// checked during reset as well
`define FWBP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fwbp reset assertion failed");

`else

`define FWBP_ASSERT(lbl, prop)
`define FWBP_ASSERT_RST(lbl, prop)

`endif

`endif

>>> design/fwbp_pkg.sv
package fwbp_pkg;

  localparam int WORD_BITS  = 64;
  localparam int WIDTH_BITS = 7;
  localparam int FILL_BITS  = 6;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [WIDTH_BITS-1:0] width_t;
  typedef logic [FILL_BITS-1:0]  fill_t;

  localparam width_t VB_RESET  = width_t'(32);
  localparam width_t WIDTH_MAX = width_t'(WORD_BITS);
  localparam word_t  ALL_ONES  = '1;

  // result slots of one beat, emitted lowest first
  typedef struct packed {
    logic pad;
    logic part;
    logic full;
  } pend_t;

  // zero width behaves as one bit, anything above a word as a full word
  function automatic width_t eff_width(input width_t vb);
    width_t w;
    w = vb;
    if (vb == '0) begin
      w = width_t'(1);
    end else if (vb > WIDTH_MAX) begin
      w = WIDTH_MAX;
    end
    return w;
  endfunction

endpackage

>>> design/fixed_width_bit_packer_top.sv
// channel | dir | ports                                   | beat when
// ------- | --- | --------------------------------------- | ------------------------
// in      | in  | in_valid in_stall in_value in_last_value | in_valid && !in_stall
// out     | out | out_valid out_stall out_packed_word       | out_valid && !out_stall
//         |     | out_last_word                           |
// cfg     | in  | cfg_wr_en cfg_wr_data                   | cfg_wr_en
//
// an input beat is registered, then packed combinationally into a result register
// holding up to three words (filled word, final partial word, zero pad word)
// the result register sends one word per cycle while out_stall is low; the next beat
// moves in as the last pending word is taken, so beats making at most one word stream
// at one per cycle. rst_n is synchronous and clears the residue and fill count
// in_stall rises only while a held input beat cannot move into the result register
`include "fixed_width_bit_packer_top_macros.svh"

module fixed_width_bit_packer_top
  import fwbp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        in_value,
  input  logic               in_last_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        out_packed_word,
  output logic               out_last_word,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data
);

  width_t vb_r;
  logic   in_valid_r;
  word_t  in_value_r;
  logic   in_last_r;
  word_t  residue_r, residue_nxt;
  fill_t  fill_r, fill_nxt;
  pend_t  pend_r, pend_nxt;
  word_t  full_word_r;
  word_t  part_word_r;
  logic   part_last_r;

  width_t w;
  word_t  v;
  word_t  merged;
  width_t total;
  logic   is_full;
  word_t  res_new;
  logic   out_take;
  logic   res_free;
  logic   a_adv;

  // packing datapath
  always_comb begin
    w       = eff_width(vb_r);
    v       = in_value_r & ~(ALL_ONES << w);
    merged  = residue_r | (v << fill_r);
    total   = width_t'(fill_r) + w;
    is_full = total >= WIDTH_MAX;
    if (!is_full) begin
      res_new = merged;
    end else if (total[FILL_BITS-1:0] == '0) begin
      res_new = '0;
    end else begin
      res_new = v >> (WIDTH_MAX - width_t'(fill_r));
    end
  end

  assign out_take = out_valid && !out_stall;
  assign res_free = (pend_r == '0) || (out_take && $onehot(pend_r));
  assign a_adv    = in_valid_r && res_free;
  assign in_stall = in_valid_r && !res_free;

  always_comb begin
    residue_nxt = residue_r;
    fill_nxt    = fill_r;
    pend_nxt    = pend_r;
    if (out_take) begin
      priority if (pend_r.full) begin
        pend_nxt.full = 1'b0;
      end else if (pend_r.part) begin
        pend_nxt.part = 1'b0;
      end else begin
        pend_nxt.pad = 1'b0;
      end
    end
    if (a_adv) begin
      residue_nxt   = res_new;
      fill_nxt      = total[FILL_BITS-1:0];
      pend_nxt.full = is_full;
      pend_nxt.part = in_last_r;
      pend_nxt.pad  = in_last_r && (total[FILL_BITS-1:0] != '0);
      if (in_last_r) begin
        residue_nxt = '0;
        fill_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r       <= VB_RESET;
      in_valid_r <= 1'b0;
      residue_r  <= '0;
      fill_r     <= '0;
      pend_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        vb_r <= cfg_wr_data;
      end
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      residue_r <= residue_nxt;
      fill_r    <= fill_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_value_r <= in_value;
      in_last_r  <= in_last_value;
    end
    if (a_adv) begin
      full_word_r <= merged;
      part_word_r <= res_new;
      part_last_r <= (total[FILL_BITS-1:0] == '0);
    end
  end

  assign out_valid = pend_r != '0;

  always_comb begin
    priority if (pend_r.full) begin
      out_packed_word = full_word_r;
      out_last_word   = 1'b0;
    end else if (pend_r.part) begin
      out_packed_word = part_word_r;
      out_last_word   = part_last_r;
    end else begin
      out_packed_word = '0;
      out_last_word   = 1'b1;
    end
  end

  `FWBP_ASSERT(a_last_word_ends_beat, out_valid && out_last_word |-> $onehot(pend_r))
  `FWBP_ASSERT(a_last_clears_state, a_adv && in_last_r |=> fill_r == '0 && residue_r == '0)
  `FWBP_ASSERT(a_pad_needs_partial, a_adv |=> !pend_r.pad || pend_r.part)
  `FWBP_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid && !in_stall)

endmodule
